@@ design/assert_macros.svh @@
// Assertion macros used by the RTL of the segment zone collision check.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising clk edge, muted while rst_n is low.
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check prop at every rising clk edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/szcc_pkg.sv @@
// Package for the segment zone collision check: beat layout, commands, states.
// Depends on nothing; used by segment_zone_collision_check and its testbench.
`default_nettype none

package szcc_pkg;

  // Default geometry
  localparam int ZoneCountDef   = 10;
  localparam int SampleCountDef = 100;

  // Field widths
  localparam int CoordW   = 13;
  localparam int ZoneIdxW = 4;

  // Slave tdata layout, lowest bit first
  localparam int ZoneIdxLsb = 0;
  localparam int XminLsb    = ZoneIdxLsb + ZoneIdxW;
  localparam int YminLsb    = XminLsb + CoordW;
  localparam int XmaxLsb    = YminLsb + CoordW;
  localparam int YmaxLsb    = XmaxLsb + CoordW;
  localparam int StartXLsb  = YmaxLsb + CoordW;
  localparam int StartYLsb  = StartXLsb + CoordW;
  localparam int EndXLsb    = StartYLsb + CoordW;
  localparam int EndYLsb    = EndXLsb + CoordW;
  localparam int InBits     = EndYLsb + CoordW;
  localparam int InTdataW   = ((InBits + 7) / 8) * 8;

  typedef enum logic {
    CMD_WRITE_ZONE = 1'b0,
    CMD_CHECK      = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SAMPLE
  } state_e;

endpackage

`default_nettype wire

@@ design/segment_zone_collision_check.sv @@
// Top level of the segment zone collision check: zone table, sample stepper, result register.
// Depends on szcc_pkg and assert_macros.svh.
//
//  channel  dir  handshake             payload
//  -------  ---  --------------------  -------------------------------------------------
//  s_axis   in   s_axis_tvalid/tready  tuser = command, tdata = zone write or segment
//  m_axis   out  m_axis_tvalid/tready  tdata = hit_mask, hit_count, path_clear
//
// A zone write is taken in ST_IDLE. A check seeds the scaled point in ST_LOAD, then
// walks the samples in ST_SAMPLE through the shared point accumulator, which is compared
// against all zones at once, up to the first sample that lands in a zone (SAMPLE_COUNT
// when none does).
// Zone table: no reset; the user must write every zone before the first check, unenforced.
// A finished result stalls the sampler until the previous beat leaves the output register.
`default_nettype none
`include "assert_macros.svh"

module segment_zone_collision_check #(
  parameter int ZONE_COUNT   = szcc_pkg::ZoneCountDef,
  parameter int SAMPLE_COUNT = szcc_pkg::SampleCountDef,
  localparam int CntW        = $clog2(ZONE_COUNT + 1),
  localparam int OutBits     = ZONE_COUNT + CntW + 1,
  localparam int OutTdataW   = ((OutBits + 7) / 8) * 8
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          s_axis_tvalid,
  output logic                         s_axis_tready,
  // tdata: zone_index, zone_xmin, zone_ymin, zone_xmax, zone_ymax,
  //        start_x, start_y, end_x, end_y, zero pad
  input  wire [szcc_pkg::InTdataW-1:0] s_axis_tdata,
  // tuser: command
  input  wire                          s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  wire                          m_axis_tready,
  // tdata: hit_mask, hit_count, path_clear, zero pad
  output logic [OutTdataW-1:0]         m_axis_tdata
);

  localparam int CW   = szcc_pkg::CoordW;
  // Scaled coordinates: |SAMPLE_COUNT * coord| and every sample point fit here
  localparam int PW   = CW + $clog2(SAMPLE_COUNT + 1);
  localparam int StpW = $clog2(SAMPLE_COUNT + 1);
  localparam logic signed [PW-1:0] Scale    = PW'(SAMPLE_COUNT);
  localparam logic [StpW-1:0]      LastStep = StpW'(SAMPLE_COUNT);

  function automatic logic signed [PW-1:0] sext_coord(input logic [CW-1:0] c);
    return {{(PW - CW){c[CW-1]}}, c};
  endfunction

  function automatic logic signed [PW-1:0] scale_coord(input logic [CW-1:0] c);
    return Scale * sext_coord(c);
  endfunction

  // Beat fields
  logic                            in_fire;
  logic                            in_check;
  logic [szcc_pkg::ZoneIdxW-1:0]   zone_idx;
  logic [CW-1:0]                   in_xmin, in_ymin, in_xmax, in_ymax;
  logic [CW-1:0]                   in_sx, in_sy, in_ex, in_ey;

  assign zone_idx = s_axis_tdata[szcc_pkg::ZoneIdxLsb +: szcc_pkg::ZoneIdxW];
  assign in_xmin  = s_axis_tdata[szcc_pkg::XminLsb +: CW];
  assign in_ymin  = s_axis_tdata[szcc_pkg::YminLsb +: CW];
  assign in_xmax  = s_axis_tdata[szcc_pkg::XmaxLsb +: CW];
  assign in_ymax  = s_axis_tdata[szcc_pkg::YmaxLsb +: CW];
  assign in_sx    = s_axis_tdata[szcc_pkg::StartXLsb +: CW];
  assign in_sy    = s_axis_tdata[szcc_pkg::StartYLsb +: CW];
  assign in_ex    = s_axis_tdata[szcc_pkg::EndXLsb +: CW];
  assign in_ey    = s_axis_tdata[szcc_pkg::EndYLsb +: CW];

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign in_check = (szcc_pkg::cmd_e'(s_axis_tuser) == szcc_pkg::CMD_CHECK);

  // Zone table, stored already scaled by SAMPLE_COUNT
  logic signed [PW-1:0] zxmin_q [ZONE_COUNT];
  logic signed [PW-1:0] zymin_q [ZONE_COUNT];
  logic signed [PW-1:0] zxmax_q [ZONE_COUNT];
  logic signed [PW-1:0] zymax_q [ZONE_COUNT];

  // Segment registers
  logic [CW-1:0]        ax_q, ay_q;
  logic signed [CW:0]   dx_q, dy_q;
  logic signed [PW-1:0] px_q, px_d, py_q, py_d;
  logic [StpW-1:0]      step_q, step_d;

  // Control
  szcc_pkg::state_e     state_q, state_d;
  logic                 out_valid_q, out_valid_d;
  logic [ZONE_COUNT-1:0] hit_mask_q, hit_mask_d;
  logic [CntW-1:0]      hit_count_q, hit_count_d;
  logic                 path_clear_q, path_clear_d;

  // Zone compare, all zones against the current sample
  logic [ZONE_COUNT-1:0] hit;
  logic [CntW-1:0]       hit_cnt;

  always_comb begin
    for (int z = 0; z < ZONE_COUNT; z++) begin
      hit[z] = (px_q >= zxmin_q[z]) && (px_q <= zxmax_q[z]) &&
               (py_q >= zymin_q[z]) && (py_q <= zymax_q[z]);
    end
  end

  always_comb begin
    hit_cnt = '0;
    for (int z = 0; z < ZONE_COUNT; z++) begin
      hit_cnt = hit_cnt + CntW'(hit[z]);
    end
  end

  // Sequencer
  always_comb begin
    state_d      = state_q;
    px_d         = px_q;
    py_d         = py_q;
    step_d       = step_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    hit_mask_d   = hit_mask_q;
    hit_count_d  = hit_count_q;
    path_clear_d = path_clear_q;
    s_axis_tready = 1'b0;
    case (state_q)
      szcc_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (in_fire && in_check) begin
          state_d = szcc_pkg::ST_LOAD;
        end
      end
      szcc_pkg::ST_LOAD: begin
        // Seed the point at the first sample: SAMPLE_COUNT*start + delta
        px_d    = Scale * sext_coord(ax_q) + PW'(dx_q);
        py_d    = Scale * sext_coord(ay_q) + PW'(dy_q);
        step_d  = StpW'(1);
        state_d = szcc_pkg::ST_SAMPLE;
      end
      szcc_pkg::ST_SAMPLE: begin
        if ((|hit) || (step_q == LastStep)) begin
          // Hold the finished sample until the output register frees up
          if (!out_valid_q || m_axis_tready) begin
            out_valid_d  = 1'b1;
            hit_mask_d   = hit;
            hit_count_d  = hit_cnt;
            path_clear_d = !(|hit);
            state_d      = szcc_pkg::ST_IDLE;
          end
        end else begin
          px_d   = px_q + PW'(dx_q);
          py_d   = py_q + PW'(dy_q);
          step_d = step_q + StpW'(1);
        end
      end
      default: begin
        state_d = szcc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= szcc_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      step_q      <= '0;
      px_q        <= '0;
      py_q        <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
      px_q        <= px_d;
      py_q        <= py_d;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk_i) begin
    hit_mask_q   <= hit_mask_d;
    hit_count_q  <= hit_count_d;
    path_clear_q <= path_clear_d;
    if (in_fire && in_check) begin
      ax_q <= in_sx;
      ay_q <= in_sy;
      dx_q <= {in_ex[CW-1], in_ex} - {in_sx[CW-1], in_sx};
      dy_q <= {in_ey[CW-1], in_ey} - {in_sy[CW-1], in_sy};
    end
    for (int z = 0; z < ZONE_COUNT; z++) begin
      // Slots beyond the table are dropped
      if (in_fire && !in_check && (zone_idx == szcc_pkg::ZoneIdxW'(z))) begin
        zxmin_q[z] <= scale_coord(in_xmin);
        zymin_q[z] <= scale_coord(in_ymin);
        zxmax_q[z] <= scale_coord(in_xmax);
        zymax_q[z] <= scale_coord(in_ymax);
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutTdataW'({path_clear_q, hit_count_q, hit_mask_q});

  // Assertions
  `ASSERT_RST(a_check_blocks_input, clk_i, rst_ni,
    (in_fire && in_check) |=> !s_axis_tready,
    "check beat did not close the input")
  `ASSERT_RST(a_step_in_range, clk_i, rst_ni,
    (state_q == szcc_pkg::ST_SAMPLE) |-> ((step_q != '0) && (step_q <= LastStep)),
    "sample step out of range")
  `ASSERT_RST(a_clear_result_empty, clk_i, rst_ni,
    m_axis_tvalid |-> (path_clear_q == ((hit_count_q == '0) && (hit_mask_q == '0))),
    "path_clear disagrees with hit mask or count")
  `ASSERT_RST(a_zone_write_no_result, clk_i, rst_ni,
    (in_fire && !in_check && !m_axis_tvalid) |=> !m_axis_tvalid,
    "zone write produced a result beat")

endmodule

`default_nettype wire

@@ verif/segment_zone_collision_check_tb.sv @@
// Self-checking testbench for segment_zone_collision_check: zone writes and segment checks
// on the stream ports, results checked against an in-bench hit predictor.
// Depends on szcc_pkg and the segment_zone_collision_check RTL.
`timescale 1ns / 1ps

module segment_zone_collision_check_tb;

  localparam int ZoneCount   = szcc_pkg::ZoneCountDef;
  localparam int SampleCount = szcc_pkg::SampleCountDef;
  localparam int CoordW      = szcc_pkg::CoordW;
  localparam int ZoneIdxW    = szcc_pkg::ZoneIdxW;
  localparam int InTdataW    = szcc_pkg::InTdataW;
  localparam int HitCntW     = $clog2(ZoneCount + 1);
  localparam int OutTdataW   = ((ZoneCount + HitCntW + 1 + 7) / 8) * 8;
  localparam int RandomItems = 550;
  localparam int TailCycles  = SampleCount + 50;

  typedef logic signed [CoordW-1:0] coord_t;

  // One result beat: hit_mask in the low bits, then hit_count, then path_clear.
  typedef struct packed {
    logic                  clear;
    logic [HitCntW-1:0]    count;
    logic [ZoneCount-1:0]  mask;
  } hit_report_t;

  typedef struct packed {
    coord_t xmin;
    coord_t ymin;
    coord_t xmax;
    coord_t ymax;
  } zone_box_t;

  // One input beat plus, for hand-checked rows, the result typed in.
  typedef struct {
    szcc_pkg::cmd_e      cmd;
    logic [ZoneIdxW-1:0] idx;
    zone_box_t           box;
    coord_t              sx;
    coord_t              sy;
    coord_t              ex;
    coord_t              ey;
    bit                  typed;
    hit_report_t         want;
  } zone_cmd_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata;
  logic                 s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OutTdataW-1:0] m_axis_tdata;

  zone_box_t   zone_mirror [ZoneCount];
  hit_report_t pending_reports [$];
  zone_cmd_t   directed_rows [$];

  int failures     = 0;
  int zone_writes  = 0;
  int checks_sent  = 0;
  int reports_seen = 0;
  int clear_paths  = 0;

  segment_zone_collision_check dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #6 clk_i = ~clk_i;

  // Hard stop: far beyond the slowest legal run.
  initial begin : watchdog
    #5_000_000;
    $display("timeout: %0d results still pending", pending_reports.size());
    $display("[segment_zone_collision_check] ERROR");
    $finish;
  end

  function automatic coord_t clamp13(int v);
    if (v < -4096) v = -4096;
    if (v > 4095) v = 4095;
    return coord_t'(v);
  endfunction

  function automatic int rand_span(int lo, int hi);
    return lo + int'($urandom_range(hi - lo, 0));
  endfunction

  function automatic int rand_extreme();
    return $urandom_range(1, 0) ? 4095 : -4096;
  endfunction

  function automatic void note_failure(string what);
    failures++;
    if (failures <= 10) $display("mismatch: %s", what);
  endfunction

  // Walk the samples 1..SampleCount on the scaled grid, all zones per sample, stop at the
  // first sample that sits in any zone. Bounds are inclusive; an inverted box never hits.
  function automatic hit_report_t predict_report(zone_cmd_t it);
    hit_report_t r;
    int ax, ay, dx, dy, px, py;
    r = '0;
    ax = it.sx;
    ay = it.sy;
    dx = int'(it.ex) - ax;
    dy = int'(it.ey) - ay;
    for (int i = 1; i <= SampleCount && r.count == 0; i++) begin
      px = SampleCount * ax + i * dx;
      py = SampleCount * ay + i * dy;
      for (int z = 0; z < ZoneCount; z++) begin
        if (px >= SampleCount * int'(zone_mirror[z].xmin) &&
            px <= SampleCount * int'(zone_mirror[z].xmax) &&
            py >= SampleCount * int'(zone_mirror[z].ymin) &&
            py <= SampleCount * int'(zone_mirror[z].ymax)) begin
          r.mask[z] = 1'b1;
          r.count   = r.count + 1'b1;
        end
      end
    end
    r.clear = (r.count == 0);
    return r;
  endfunction

  // Update the zone mirror or queue the expected report for one accepted beat.
  function automatic void apply_beat(zone_cmd_t it);
    if (it.cmd == szcc_pkg::CMD_WRITE_ZONE) begin
      // slots past the table are dropped by the block
      if (it.idx < ZoneCount) begin
        zone_mirror[it.idx] = it.box;
        zone_writes++;
      end
    end else begin
      pending_reports.push_back(it.typed ? it.want : predict_report(it));
      checks_sent++;
    end
  endfunction

  function automatic logic [InTdataW-1:0] pack_beat(zone_cmd_t it);
    logic [InTdataW-1:0] d;
    d = '0;
    d[szcc_pkg::ZoneIdxLsb +: ZoneIdxW] = it.idx;
    d[szcc_pkg::XminLsb +: CoordW]      = it.box.xmin;
    d[szcc_pkg::YminLsb +: CoordW]      = it.box.ymin;
    d[szcc_pkg::XmaxLsb +: CoordW]      = it.box.xmax;
    d[szcc_pkg::YmaxLsb +: CoordW]      = it.box.ymax;
    d[szcc_pkg::StartXLsb +: CoordW]    = it.sx;
    d[szcc_pkg::StartYLsb +: CoordW]    = it.sy;
    d[szcc_pkg::EndXLsb +: CoordW]      = it.ex;
    d[szcc_pkg::EndYLsb +: CoordW]      = it.ey;
    return d;
  endfunction

  function automatic zone_cmd_t zone_row(int idx, int xmin, int ymin, int xmax, int ymax);
    zone_cmd_t it;
    it          = '{default: '0, cmd: szcc_pkg::CMD_WRITE_ZONE};
    it.idx      = ZoneIdxW'(idx);
    it.box.xmin = clamp13(xmin);
    it.box.ymin = clamp13(ymin);
    it.box.xmax = clamp13(xmax);
    it.box.ymax = clamp13(ymax);
    return it;
  endfunction

  function automatic zone_cmd_t check_row(int sx, int sy, int ex, int ey, bit typed,
                                          int mask, int count);
    zone_cmd_t it;
    it            = '{default: '0, cmd: szcc_pkg::CMD_CHECK};
    it.sx         = clamp13(sx);
    it.sy         = clamp13(sy);
    it.ex         = clamp13(ex);
    it.ey         = clamp13(ey);
    it.typed      = typed;
    it.want.mask  = ZoneCount'(mask);
    it.want.count = HitCntW'(count);
    it.want.clear = (count == 0);
    return it;
  endfunction

  // Random beat: every field gets random bits first, so fields the command ignores
  // still toggle; the fields that matter are then shaped.
  function automatic zone_cmd_t random_item();
    zone_cmd_t it;
    int mode, cx, cy, hw, hh, z;
    it.cmd      = szcc_pkg::cmd_e'($urandom_range(1, 0));
    it.idx      = ZoneIdxW'($urandom);
    it.box.xmin = coord_t'($urandom);
    it.box.ymin = coord_t'($urandom);
    it.box.xmax = coord_t'($urandom);
    it.box.ymax = coord_t'($urandom);
    it.sx       = coord_t'($urandom);
    it.sy       = coord_t'($urandom);
    it.ex       = coord_t'($urandom);
    it.ey       = coord_t'($urandom);
    it.typed    = 1'b0;
    it.want     = '0;
    mode        = $urandom_range(9, 0);
    if ($urandom_range(4, 0) == 0) begin
      it.cmd = szcc_pkg::CMD_WRITE_ZONE;
      if ($urandom_range(7, 0) != 0) it.idx = ZoneIdxW'($urandom_range(ZoneCount - 1, 0));
      cx = rand_span(-4096, 4095);
      cy = rand_span(-4096, 4095);
      hw = $urandom_range(900, 0);
      hh = $urandom_range(900, 0);
      if (mode < 7) begin
        // ordinary box around a random center
        it.box.xmin = clamp13(cx - hw);
        it.box.xmax = clamp13(cx + hw);
        it.box.ymin = clamp13(cy - hh);
        it.box.ymax = clamp13(cy + hh);
      end else if (mode == 7) begin
        // inverted on one axis (unless clamped at the field edge): can never be hit
        it.box.xmin = clamp13(cx + hw + 1);
        it.box.xmax = clamp13(cx);
        it.box.ymin = clamp13(cy - hh);
        it.box.ymax = clamp13(cy + hh);
        if ($urandom_range(1, 0)) begin
          it.box.xmin = clamp13(cx - hw);
          it.box.ymin = clamp13(cy + hh + 1);
          it.box.ymax = clamp13(cy);
        end
      end else if (mode == 8) begin
        it.box.xmin = clamp13(rand_extreme());
        it.box.ymin = clamp13(rand_extreme());
        it.box.xmax = clamp13(rand_extreme());
        it.box.ymax = clamp13(rand_extreme());
      end
    end else begin
      it.cmd = szcc_pkg::CMD_CHECK;
      z = $urandom_range(ZoneCount - 1, 0);
      if (mode < 5 && zone_mirror[z].xmin <= zone_mirror[z].xmax &&
          zone_mirror[z].ymin <= zone_mirror[z].ymax) begin
        // aim the end point into a live zone so the walk stops part way
        it.ex = clamp13(rand_span(zone_mirror[z].xmin, zone_mirror[z].xmax));
        it.ey = clamp13(rand_span(zone_mirror[z].ymin, zone_mirror[z].ymax));
      end else if (mode == 5) begin
        it.ex = it.sx;
        it.ey = it.sy;
      end else if (mode == 6) begin
        it.sx = clamp13(rand_extreme());
        it.sy = clamp13(rand_extreme());
        it.ex = clamp13(rand_extreme());
        it.ey = clamp13(rand_extreme());
      end else if (mode == 7) begin
        it.ex = clamp13(it.sx + rand_span(-200, 200));
        it.ey = clamp13(it.sy + rand_span(-200, 200));
      end
    end
    return it;
  endfunction

  // Present one beat after `gap` idle cycles; with `drain`, also hold valid low until
  // every pending report has arrived. Returns after the accepting edge.
  task automatic send_beat(zone_cmd_t it, int gap, bit drain);
    int idle;
    idle = (drain && gap == 0) ? 1 : gap;
    @(negedge clk_i);
    if (idle > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (idle) @(negedge clk_i);
      while (drain && pending_reports.size() != 0) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.cmd;
    s_axis_tdata  <= pack_beat(it);
    do @(posedge clk_i); while (!s_axis_tready);
    apply_beat(it);
  endtask

  task automatic take_report();
    hit_report_t got, want;
    got.mask  = m_axis_tdata[0 +: ZoneCount];
    got.count = m_axis_tdata[ZoneCount +: HitCntW];
    got.clear = m_axis_tdata[ZoneCount + HitCntW];
    reports_seen++;
    if (got.clear) clear_paths++;
    if (pending_reports.size() == 0) begin
      note_failure($sformatf("result beat with nothing pending: mask=%h count=%0d clear=%b",
                             got.mask, got.count, got.clear));
    end else begin
      want = pending_reports.pop_front();
      if (got.mask !== want.mask || got.count !== want.count || got.clear !== want.clear)
        note_failure($sformatf(
          "report %0d: mask exp %h got %h, count exp %0d got %0d, clear exp %b got %b",
          reports_seen, want.mask, got.mask, want.count, got.count,
          want.clear, got.clear));
    end
  endtask

  // Result side: random stalls, a stall-free stretch, and one long hold-off
  // that fills the block and backs up its input while the sender keeps offering beats.
  initial begin : report_sink
    int  stall;
    bit  held_off;
    held_off      = 1'b0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held_off && reports_seen == 40) begin
        held_off = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (600) @(negedge clk_i);
      end else begin
        stall = (reports_seen >= 150 && reports_seen < 220) ? 0 : $urandom_range(5, 0);
        if (stall > 0) begin
          m_axis_tready <= 1'b0;
          repeat (stall) @(negedge clk_i);
        end
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      take_report();
    end
  end

  initial begin : stimulus
    zone_cmd_t it;
    int        counted;
    int        gap;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser  = szcc_pkg::CMD_WRITE_ZONE;
    s_axis_tdata  = '0;
    counted       = 0;
    foreach (zone_mirror[z]) zone_mirror[z] = '0;

    // Directed table. Every zone is loaded before the first check.
    directed_rows.push_back(zone_row(0, -4096, -4096, -4000, -4000));
    directed_rows.push_back(zone_row(1, 4000, 4000, 4095, 4095));
    directed_rows.push_back(zone_row(2, 0, 0, 100, 100));
    directed_rows.push_back(zone_row(3, 50, 50, 200, 200));
    directed_rows.push_back(zone_row(4, 500, 500, 400, 600));      // inverted in x
    directed_rows.push_back(zone_row(5, -4096, 3000, -3000, 4095));
    directed_rows.push_back(zone_row(6, 3000, -4096, 4095, -3000));
    directed_rows.push_back(zone_row(7, -1000, -1000, -900, -900));
    directed_rows.push_back(zone_row(8, 1000, -2000, 1100, -1900));
    directed_rows.push_back(zone_row(9, -2000, 1000, -1900, 1100));
    // first hit lands on the corner of zone 2 halfway along
    directed_rows.push_back(check_row(-50, -50, 50, 50, 1, 'h004, 1));
    // full diagonal: start lies in zone 0 but is skipped, first sample still inside
    directed_rows.push_back(check_row(-4096, -4096, 4095, 4095, 1, 'h001, 1));
    // zero-length segment at the top corner
    directed_rows.push_back(check_row(4095, 4095, 4095, 4095, 1, 'h002, 1));
    // overlap of zones 2 and 3
    directed_rows.push_back(check_row(60, 60, 60, 60, 1, 'h00c, 2));
    // runs through the inverted zone only: clear
    directed_rows.push_back(check_row(450, 450, 450, 550, 1, 'h000, 0));
    directed_rows.push_back(check_row(-4096, 4095, 4095, -4096, 1, 'h020, 1));
    // slots past the table: both must be dropped, so the next check stays clear
    directed_rows.push_back(zone_row(10, -4096, -4096, 4095, 4095));
    directed_rows.push_back(zone_row(15, -4096, -4096, 4095, 4095));
    directed_rows.push_back(check_row(2000, 2000, 2000, 2000, 1, 'h000, 0));
    // full-field zone overlapping the corner zone
    directed_rows.push_back(zone_row(2, -4096, -4096, 4095, 4095));
    directed_rows.push_back(check_row(-4096, -4096, -4096, -4096, 1, 'h005, 2));
    directed_rows.push_back(zone_row(2, 0, 0, 100, 100));
    directed_rows.push_back(check_row(-300, -300, 300, 300, 0, 0, 0));
    directed_rows.push_back(check_row(900, -2500, 1200, -1500, 0, 0, 0));

    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[k]) send_beat(directed_rows[k], $urandom_range(5, 0), 1'b0);

    // Random part: mostly checks, up to half aimed at live zones, with zone rewrites mixed in.
    // Writes to slots past the table do not count toward the item total.
    while (counted < RandomItems) begin
      it  = random_item();
      gap = (counted >= 100 && counted < 160) ? 0 : $urandom_range(5, 0);
      send_beat(it, gap, counted == 250);
      if (it.cmd == szcc_pkg::CMD_CHECK || it.idx < ZoneCount) counted++;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("covered %0d zone writes and %0d segment checks", zone_writes, checks_sent);
    $display("%0d reports received, %0d clear paths, %0d mismatches",
             reports_seen, clear_paths, failures);
    if (failures == 0) begin
      $display("[segment_zone_collision_check] OK");
    end else begin
      $display("[segment_zone_collision_check] ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+design
design/szcc_pkg.sv
design/segment_zone_collision_check.sv
verif/segment_zone_collision_check_tb.sv
